FILE: design/mups_pkg.sv
package mups_pkg;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic       en;
    logic [7:0] index;
    byte_t      value;
    logic       wild;
  } sig_write_t;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 96;

  localparam logic REG_PATTERN_LENGTH = 1'b0;
  localparam logic REG_BASE_ADDRESS   = 1'b1;

  localparam logic [6:0] PATTERN_LENGTH_RESET = 7'd1;

endpackage

FILE: design/masked_unique_pattern_scan.sv
// Wildcard byte signature scanner. Operation-0 words (tuser low) load one signature entry;
// operation-1 words stream region bytes, and tlast marks the last byte of a region, which
// returns one result word with the match count, the unique flag and the match address.
// The block takes one word per clock unless a stalled result word holds the input register:
// every window position is compared against all PATTERN_MAX signature lanes at once in a
// single registered pass, and the result word is registered from the word carrying tlast.
// A stalled result word holds; scanning goes on until the next word carrying tlast reaches
// the input register, which then waits for the result word to be taken.
module masked_unique_pattern_scan
  import mups_pkg::*;
#(
  parameter int PATTERN_MAX = 64,
  localparam int LEN_W = $clog2(PATTERN_MAX + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // entry_index[5:0], entry_value[13:6], entry_wildcard[14], region_byte[22:15], zero[23]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // operation[0]
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // match_address[63:0], match_total[95:64]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // unique_found[0]
  output logic                   m_axis_tuser
);

  logic [6:0]  pattern_length;
  logic [63:0] base_address;

  logic        s1_valid;
  logic        s1_op;
  logic [5:0]  s1_index;
  byte_t       s1_value;
  logic        s1_wild;
  byte_t       s1_byte;
  logic        s1_last;
  logic        s1_emits;
  logic        s1_go;
  logic        scan;

  byte_t [PATTERN_MAX-1:0] window;
  byte_t [PATTERN_MAX-1:0] window_next;

  sig_write_t       sig_wr;
  logic [LEN_W-1:0] len_eff;
  logic             hit;
  logic             hit_now;

  logic [31:0] bytes_seen;
  logic [31:0] bytes_seen_next;
  logic [31:0] matches_seen;
  logic [31:0] matches_seen_next;
  logic [31:0] last_match_offset;
  logic [31:0] last_match_offset_next;
  logic        unique_next;
  logic [63:0] address_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= PATTERN_LENGTH_RESET;
      base_address   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[6:0];
        REG_BASE_ADDRESS:   base_address   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_emits      = s1_op && s1_last;
  assign s1_go         = s1_valid && (!s1_emits || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_go;
  assign scan          = s1_go && s1_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_op    <= s_axis_tuser;
      s1_index <= s_axis_tdata[5:0];
      s1_value <= s_axis_tdata[13:6];
      s1_wild  <= s_axis_tdata[14];
      s1_byte  <= s_axis_tdata[22:15];
      s1_last  <= s_axis_tlast;
    end
  end

  // oldest byte in lane zero, newest in the top lane
  always_comb begin
    for (int j = 0; j < PATTERN_MAX - 1; j++) begin
      window_next[j] = window[j+1];
    end
    window_next[PATTERN_MAX-1] = s1_byte;
  end

  always_ff @(posedge clk) begin
    if (scan) begin
      window <= window_next;
    end
  end

  always_comb begin
    sig_wr.en    = s1_go && !s1_op && ({3'b0, s1_index} < 9'(PATTERN_MAX));
    sig_wr.index = {2'b0, s1_index};
    sig_wr.value = s1_value;
    sig_wr.wild  = s1_wild;
  end

  always_comb begin
    if ({2'b0, pattern_length} > 9'(PATTERN_MAX)) begin
      len_eff = LEN_W'(PATTERN_MAX);
    end else begin
      len_eff = LEN_W'(pattern_length);
    end
  end

  mups_match #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_match (
    .clk    (clk),
    .sig_wr (sig_wr),
    .window (window_next),
    .len    (len_eff),
    .hit    (hit)
  );

  always_comb begin
    bytes_seen_next = (bytes_seen == '1) ? bytes_seen : bytes_seen + 32'd1;
    hit_now = hit && (bytes_seen_next >= 32'(len_eff));
    matches_seen_next = (hit_now && (matches_seen != '1)) ? matches_seen + 32'd1
                                                          : matches_seen;
    last_match_offset_next = hit_now ? bytes_seen_next - 32'(len_eff) : last_match_offset;
    unique_next  = (matches_seen_next == 32'd1);
    address_next = unique_next ? base_address + {32'b0, last_match_offset_next} : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen        <= '0;
      matches_seen      <= '0;
      last_match_offset <= '0;
    end else if (scan) begin
      if (s1_last) begin
        bytes_seen        <= '0;
        matches_seen      <= '0;
        last_match_offset <= '0;
      end else begin
        bytes_seen        <= bytes_seen_next;
        matches_seen      <= matches_seen_next;
        last_match_offset <= last_match_offset_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (scan && s1_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan && s1_last) begin
      m_axis_tdata <= {matches_seen_next, address_next};
      m_axis_tuser <= unique_next;
    end
  end

endmodule

FILE: design/mups_match.sv
module mups_match
  import mups_pkg::*;
#(
  parameter int PATTERN_MAX = 64,
  localparam int LEN_W = $clog2(PATTERN_MAX + 1),
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
  input  logic                      clk,
  input  sig_write_t                sig_wr,
  input  byte_t [PATTERN_MAX-1:0]   window,
  input  logic [LEN_W-1:0]          len,
  output logic                      hit
);

  byte_t sig_value [PATTERN_MAX];
  logic  sig_wild  [PATTERN_MAX];

  logic [LEN_W:0]             gap_wide;
  logic [IDX_W-1:0]           gap;
  logic [PATTERN_MAX*8-1:0]   level [IDX_W+1];
  byte_t [PATTERN_MAX-1:0]    aligned;
  logic [PATTERN_MAX-1:0]     lane_ok;

  always_ff @(posedge clk) begin
    if (sig_wr.en) begin
      sig_value[sig_wr.index[IDX_W-1:0]] <= sig_wr.value;
      sig_wild[sig_wr.index[IDX_W-1:0]]  <= sig_wr.wild;
    end
  end

  // align the newest len bytes of the window to lane zero
  assign gap_wide = (LEN_W + 1)'(PATTERN_MAX) - {1'b0, len};
  assign gap      = gap_wide[IDX_W-1:0];

  always_comb begin
    level[0] = window;
    for (int b = 0; b < IDX_W; b++) begin
      level[b+1] = gap[b] ? (level[b] >> (8 << b)) : level[b];
    end
  end

  assign aligned = level[IDX_W];

  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      lane_ok[j] = sig_wild[j] || (sig_value[j] == aligned[j]) || (LEN_W'(j) >= len);
    end
  end

  assign hit = (&lane_ok) && (len != '0);

endmodule

FILE: design/mups_checker.sv
module mups_checker
  import mups_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  // hold a stalled result word
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("stalled result word changed");

  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result word valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[95:64] == 32'd1)))
    else $error("unique flag disagrees with match total");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[63:0] == 64'd0))
    else $error("nonzero address without a unique match");

endmodule

bind masked_unique_pattern_scan mups_checker u_mups_checker (.*);
